@@ design/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared constants and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

   // Permutation size and index width.
   localparam int SBOX_DEPTH = 256;
   localparam int IDX_W      = 8;

   // Default limit on stored key bytes.
   localparam int KEY_MAX_DEF = 256;

   // Key count width: holds 0 up to the full store depth.
   localparam int CNT_W = 9;

   // Commands from the controller to the datapath; several may be set together,
   // such as capture, key write and schedule start at accept.
   typedef struct packed {
      logic capture;     // Register the accepted input byte.
      logic key_wr;      // Append the accepted byte to the key store.
      logic sched_start; // Latch the key length, clear n, j and key position.
      logic init_wr;     // Write sbox[n] = n and step n.
      logic ks_rd;       // Read sbox[n] and key[kpos].
      logic ks_j;        // Update j from sbox[n] and the key byte, read sbox[j].
      logic ks_wa;       // Write sbox[n] = old sbox[j].
      logic ks_wb;       // Write sbox[j] = old sbox[n], step n and kpos.
      logic sched_done;  // Clear i, j and the key count.
      logic gen_i;       // Step i and read sbox[i].
      logic gen_j;       // Update j and read sbox[j].
      logic gen_wa;      // Write sbox[i] = old sbox[j], read sbox[t].
      logic gen_wb;      // Write sbox[j] = old sbox[i], capture keystream.
      logic rsp_load;    // Load the result register.
      logic rsp_no_key;  // The loaded result is the no-key answer.
   } rc4_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_last; // The schedule index stands at its final entry.
   } rc4_status_type;

endpackage

@@ design/rc4_ctrl.sv @@
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key loading, key scheduling and keystream generation, and owns
// both handshakes.
// ----------------------------------------------------------------------------
module rc4_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic                    req_last_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rc4_pkg::rc4_cmd_type    cmd,
   input  rc4_pkg::rc4_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_WA,
      ST_KS_WB,
      ST_GEN_I,
      ST_GEN_J,
      ST_GEN_WA,
      ST_GEN_WB,
      ST_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      key_ready_ff, key_ready_in;
   logic      no_key_ff, no_key_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      key_ready_in = key_ready_ff;
      no_key_in    = no_key_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (!req_mode) begin
                  cmd.key_wr = 1'b1;
                  if (req_last_key) begin
                     cmd.sched_start = 1'b1;
                     state_in        = ST_INIT;
                  end
               end else if (key_ready_ff) begin
                  no_key_in = 1'b0;
                  state_in  = ST_GEN_I;
               end else begin
                  no_key_in = 1'b1;
                  state_in  = ST_RSP;
               end
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.n_last) begin
               state_in = ST_KS_RD;
            end
         end
         ST_KS_RD: begin
            cmd.ks_rd = 1'b1;
            state_in  = ST_KS_J;
         end
         ST_KS_J: begin
            cmd.ks_j = 1'b1;
            state_in = ST_KS_WA;
         end
         ST_KS_WA: begin
            cmd.ks_wa = 1'b1;
            state_in  = ST_KS_WB;
         end
         ST_KS_WB: begin
            cmd.ks_wb = 1'b1;
            if (status.n_last) begin
               cmd.sched_done = 1'b1;
               key_ready_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_KS_RD;
            end
         end
         ST_GEN_I: begin
            cmd.gen_i = 1'b1;
            state_in  = ST_GEN_J;
         end
         ST_GEN_J: begin
            cmd.gen_j = 1'b1;
            state_in  = ST_GEN_WA;
         end
         ST_GEN_WA: begin
            cmd.gen_wa = 1'b1;
            state_in   = ST_GEN_WB;
         end
         ST_GEN_WB: begin
            cmd.gen_wb = 1'b1;
            state_in   = ST_RSP;
         end
         ST_RSP: begin
            // Wait until the result register is free or being emptied.
            if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_no_key = no_key_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result valid flag follows loads and the output handshake.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ready_ff <= 1'b0;
         no_key_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ready_ff <= key_ready_in;
         no_key_ff    <= no_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/rc4_datapath.sv @@
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation memory, key store, index registers and the result register.
// ----------------------------------------------------------------------------
module rc4_datapath #(
   parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_in_byte,
   input  rc4_pkg::rc4_cmd_type    cmd,
   output rc4_pkg::rc4_status_type status,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_no_key
);

   localparam int IW = rc4_pkg::IDX_W;
   localparam int CW = rc4_pkg::CNT_W;

   // Memories: permutation with two registered read ports, key store with one.
   logic [7:0] sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [7:0] key_mem  [rc4_pkg::SBOX_DEPTH];

   logic [IW-1:0] rda_addr, rdb_addr, wr_addr;
   logic [7:0]    wr_data;
   logic          wr_en;
   logic [7:0]    rda_ff, rdb_ff, key_rd_ff;

   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] kpos_ff, kpos_in;
   logic [IW-1:0] t_ff, t_in;
   logic [CW-1:0] key_count_ff, key_count_in;
   logic [CW-1:0] key_len_ff, key_len_in;
   logic [7:0]    in_byte_ff;
   logic [7:0]    si_ff, sj_ff, ks_ff, ks_in;
   logic [7:0]    out_byte_ff;
   logic          no_key_ff;

   logic          key_room;
   logic [CW-1:0] count_next;
   logic [CW-1:0] kpos_step;
   logic [IW-1:0] j_ks, j_gen, i_step;

   assign key_room   = key_count_ff < CW'(KEY_MAX);
   assign count_next = (cmd.key_wr && key_room) ? key_count_ff + 1'b1 : key_count_ff;
   assign kpos_step  = {1'b0, kpos_ff} + 1'b1;
   assign j_ks       = j_ff + rda_ff + key_rd_ff;
   assign j_gen      = j_ff + rda_ff;
   assign i_step     = i_ff + 1'b1;

   assign status.n_last = (n_ff == {IW{1'b1}});

   // Read address selection.
   always_comb begin
      rda_addr = n_ff;
      if (cmd.gen_i) begin
         rda_addr = i_step;
      end
      rdb_addr = t_in;
      if (cmd.ks_j) begin
         rdb_addr = j_ks;
      end else if (cmd.gen_j) begin
         rdb_addr = j_gen;
      end
   end

   // Write port selection for fill and swaps.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = n_ff;
      wr_data = n_ff;
      if (cmd.ks_wa) begin
         wr_data = rdb_ff;
      end else if (cmd.ks_wb || cmd.gen_wb) begin
         wr_addr = j_ff;
         wr_data = si_ff;
      end else if (cmd.gen_wa) begin
         wr_addr = i_ff;
         wr_data = rdb_ff;
      end else if (!cmd.init_wr) begin
         wr_en = 1'b0;
      end
   end

   // Permutation memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sbox_mem[wr_addr] <= wr_data;
      end
      rda_ff <= sbox_mem[rda_addr];
      rdb_ff <= sbox_mem[rdb_addr];
   end

   // Key store.
   always_ff @(posedge clock) begin
      if (cmd.key_wr && key_room) begin
         key_mem[key_count_ff[IW-1:0]] <= req_in_byte;
      end
      if (cmd.ks_rd) begin
         key_rd_ff <= key_mem[kpos_ff];
      end
   end

   // Index and count updates.
   always_comb begin
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      kpos_in      = kpos_ff;
      key_count_in = count_next;
      key_len_in   = key_len_ff;
      t_in         = t_ff;
      if (cmd.sched_start) begin
         n_in       = '0;
         j_in       = '0;
         kpos_in    = '0;
         key_len_in = (count_next == '0) ? CW'(1) : count_next;
      end
      if (cmd.init_wr) begin
         n_in = n_ff + 1'b1;
      end
      if (cmd.ks_j) begin
         j_in = j_ks;
      end
      if (cmd.ks_wb) begin
         n_in    = n_ff + 1'b1;
         kpos_in = (kpos_step >= key_len_ff) ? '0 : kpos_step[IW-1:0];
      end
      if (cmd.sched_done) begin
         i_in         = '0;
         j_in         = '0;
         key_count_in = '0;
      end
      if (cmd.gen_i) begin
         i_in = i_step;
      end
      if (cmd.gen_j) begin
         j_in = j_gen;
      end
      if (cmd.gen_wa) begin
         t_in = si_ff + rdb_ff;
      end
   end

   // Keystream byte with bypass of the two swap writes.
   always_comb begin
      if (t_ff == i_ff) begin
         ks_in = sj_ff;
      end else if (t_ff == j_ff) begin
         ks_in = si_ff;
      end else begin
         ks_in = rdb_ff;
      end
   end

   // Control-side counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      kpos_ff    <= kpos_in;
      key_len_ff <= key_len_in;
      t_ff       <= t_in;
      if (cmd.capture) begin
         in_byte_ff <= req_in_byte;
      end
      if (cmd.ks_j || cmd.gen_j) begin
         si_ff <= rda_ff;
      end
      if (cmd.gen_wa) begin
         sj_ff <= rdb_ff;
      end
      if (cmd.gen_wb) begin
         ks_ff <= ks_in;
      end
      if (cmd.rsp_load) begin
         out_byte_ff <= cmd.rsp_no_key ? 8'h00 : (in_byte_ff ^ ks_ff);
         no_key_ff   <= cmd.rsp_no_key;
      end
   end

   assign rsp_out_byte = out_byte_ff;
   assign rsp_no_key   = no_key_ff;

endmodule

@@ design/rc4_stream_cipher_top.sv @@
// Key byte: accepted while idle; a final key byte adds scheduling (a fill of
// all 256 entries, then read, j update and two swap writes for each entry).
// Data byte: result loaded after four dependent accesses to the single
// permutation memory; no new item is accepted before that load, which waits
// for a free result register. Data before any key: the no-key result.
// Reset clears i, j, key count and control flags; n, kpos and memories stay.
// ----------------------------------------------------------------------------
// RC4 stream cipher top level
// Joins the controller and the datapath; one byte per item in each direction.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top #(
   parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_key,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_no_key
);

   rc4_pkg::rc4_cmd_type    cmd;
   rc4_pkg::rc4_status_type status;

   // Sequencer for key load, schedule and generation.
   rc4_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_last_key (req_last_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   // Memories and arithmetic.
   rc4_datapath #(
      .KEY_MAX (KEY_MAX)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_in_byte  (req_in_byte),
      .cmd          (cmd),
      .status       (status),
      .rsp_out_byte (rsp_out_byte),
      .rsp_no_key   (rsp_no_key)
   );

endmodule
